@@ hw/rtl/bacs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacs_pkg: shared types and constants for the bcd alarm clock
// Time word layout, request and event codes, register indexes.
// ----------------------------------------------------------------------------
package bacs_pkg;

    localparam int TIME_W = 22;
    localparam int TPS_W  = 8;
    localparam int SNZ_W  = 8;
    localparam int CFG_IDX_W = 2;

    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SET    = 2'd1,
        REQ_SNOOZE = 2'd2,
        REQ_CANCEL = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RING = 2'd1,
        EV_STOP = 2'd2
    } t_event;

    localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd2;

    // digit roll-over limits
    localparam int DEC_LIMIT  = 10;
    localparam int SEX_LIMIT  = 6;
    localparam int HT_WRAP    = 2;
    localparam int HU_WRAP    = 4;
    localparam int MIN_PER_HR = 60;
    localparam int HR_PER_DAY = 24;

    localparam logic [TPS_W-1:0] TPS_RESET = 8'd1;

endpackage

@@ hw/rtl/bacs_sec_adv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacs_sec_adv: one-second advance of a packed bcd time
// Ripple of digit carries with a wrap at 24:00, no digit checking.
// ----------------------------------------------------------------------------
module bacs_sec_adv
    import bacs_pkg::*;
(
    input  t_time i_time,
    output t_time o_time
);

    logic [4:0] su, st, mu, mt, hu;
    logic [3:0] su_n, st_n, mu_n, mt_n, hu_n, hu_w;
    logic [2:0] ht;
    logic [1:0] ht_w;
    logic       c0, c1, c2, c3, c4, wrap;

    always_comb begin
        su   = {1'b0, i_time[3:0]} + 5'd1;
        c0   = (su >= 5'(DEC_LIMIT));
        su_n = c0 ? 4'd0 : su[3:0];

        st   = {1'b0, i_time[7:4]} + {4'd0, c0};
        c1   = (st >= 5'(SEX_LIMIT));
        st_n = c1 ? 4'd0 : st[3:0];

        mu   = {1'b0, i_time[11:8]} + {4'd0, c1};
        c2   = (mu >= 5'(DEC_LIMIT));
        mu_n = c2 ? 4'd0 : mu[3:0];

        mt   = {1'b0, i_time[15:12]} + {4'd0, c2};
        c3   = (mt >= 5'(SEX_LIMIT));
        mt_n = c3 ? 4'd0 : mt[3:0];

        hu   = {1'b0, i_time[19:16]} + {4'd0, c3};
        c4   = (hu >= 5'(DEC_LIMIT));
        hu_n = c4 ? 4'd0 : hu[3:0];

        // hour tens widened by one bit so a count of four still wraps
        ht   = {1'b0, i_time[21:20]} + {2'd0, c4};
        wrap = (ht >= 3'(HT_WRAP)) && (hu_n >= 4'(HU_WRAP));
        hu_w = wrap ? 4'd0 : hu_n;
        ht_w = wrap ? 2'd0 : ht[1:0];

        o_time = {ht_w, hu_w, mt_n, mu_n, st_n, su_n};
    end

endmodule

@@ hw/rtl/bacs_snz_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacs_snz_calc: snooze time from alarm time plus a minute count
// Minutes and hours are wrapped separately with small constant compares.
// ----------------------------------------------------------------------------
module bacs_snz_calc
    import bacs_pkg::*;
(
    input  t_time            i_alarm,
    input  logic [SNZ_W-1:0] i_minutes,
    output t_time            o_snz_time
);

    logic [5:0] hrs;      // up to 45 with bad digits
    logic [7:0] mins;     // up to 165 with bad digits
    logic [8:0] msum;     // up to 420
    logic [2:0] hcarry;
    logic [5:0] mrem;
    logic [5:0] hsum;
    logic [4:0] hmod;
    logic [2:0] mt;
    logic [1:0] ht;
    logic [5:0] mu_full;
    logic [4:0] hu_full;

    always_comb begin
        hrs  = 6'({4'd0, i_alarm[21:20]} * 6'(DEC_LIMIT)) + {2'd0, i_alarm[19:16]};
        mins = 8'({4'd0, i_alarm[15:12]} * 8'(DEC_LIMIT)) + {4'd0, i_alarm[11:8]};
        msum = {1'b0, mins} + {1'b0, i_minutes};

        // whole hours in the minute sum, at most seven
        hcarry = 3'd0;
        for (int k = 1; k <= 7; k++) begin
            if (msum >= 9'(k * MIN_PER_HR)) begin
                hcarry = 3'(k);
            end
        end
        mrem = 6'(msum - 9'({6'd0, hcarry} * 9'(MIN_PER_HR)));

        hsum = hrs + {3'd0, hcarry};
        if (hsum >= 6'(2 * HR_PER_DAY)) begin
            hmod = 5'(hsum - 6'(2 * HR_PER_DAY));
        end else if (hsum >= 6'(HR_PER_DAY)) begin
            hmod = 5'(hsum - 6'(HR_PER_DAY));
        end else begin
            hmod = hsum[4:0];
        end

        mt = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (mrem >= 6'(k * DEC_LIMIT)) begin
                mt = 3'(k);
            end
        end
        mu_full = mrem - 6'({3'd0, mt} * 6'(DEC_LIMIT));

        ht = 2'd0;
        for (int k = 1; k <= 2; k++) begin
            if (hmod >= 5'(k * DEC_LIMIT)) begin
                ht = 2'(k);
            end
        end
        hu_full = hmod - 5'({3'd0, ht} * 5'(DEC_LIMIT));

        o_snz_time = {ht, hu_full[3:0], {1'b0, mt}, mu_full[3:0], i_alarm[7:0]};
    end

endmodule

@@ hw/rtl/bcd_alarm_clock_with_snooze.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_alarm_clock_with_snooze: 24-hour packed bcd clock with alarm and snooze
//
// Request words (tick, set time, snooze, cancel) arrive on the input channel
// (i_in_valid / o_in_stall); one result word per request leaves on the
// output channel (o_out_valid / i_out_stall) with the time, the time-set
// flag, the alarm event and the snooze flag.
// A word is captured in the input register; when it advances, the clock
// state is updated and the result register loaded. Throughput is one word per
// cycle unless the receiver stalls; the whole update is a single pass of
// bcd carry and constant-compare logic between the two registers.
// When the receiver stalls, the result register holds; the input register
// takes one more word, then o_in_stall rises until the result drains.
// Registers are written through i_cfg_valid / o_cfg_ready (always ready),
// index 0 ticks per second, 1 alarm time, 2 alarm enable; write them only
// while no word is in flight.
// Reset (synchronous, active low) clears the time to 00:00:00, the
// prescaler, the time-set and snooze flags, and sets ticks per second to 1
// with the alarm at 00:00:00 and disabled.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_with_snooze
    import bacs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [TIME_W-1:0]    i_new_time,
    input  logic [SNZ_W-1:0]     i_snooze_minutes,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TIME_W-1:0]    o_time_now,
    output logic                 o_time_valid,
    output logic [1:0]           o_alarm_event,
    output logic                 o_snoozed,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    // input register
    logic             r_in_valid;
    t_req             r_req;
    t_time            r_new_time;
    logic [SNZ_W-1:0] r_snz_min;

    // clock state
    t_time            r_clock, n_clock;
    logic [TPS_W-1:0] r_tick, n_tick;
    logic             r_time_set, n_time_set;
    logic             r_snz_pend, n_snz_pend;
    t_time            r_snz_time, n_snz_time;
    t_event           n_event;

    // configuration
    logic [TPS_W-1:0] r_tps;
    t_time            r_alarm;
    logic             r_alarm_en;

    // result register
    logic             r_out_valid;
    t_time            r_time_now;
    logic             r_time_valid;
    t_event           r_event;
    logic             r_snoozed;

    logic             in_acc;
    logic             adv;
    logic [TPS_W-1:0] tick_inc;
    t_time            adv_time;
    t_time            snz_calc;

    bacs_sec_adv u_sec_adv (
        .i_time (r_clock),
        .o_time (adv_time)
    );

    bacs_snz_calc u_snz_calc (
        .i_alarm    (r_alarm),
        .i_minutes  (r_snz_min),
        .o_snz_time (snz_calc)
    );

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_valid;
    assign o_time_now    = r_time_now;
    assign o_time_valid  = r_time_valid;
    assign o_alarm_event = r_event;
    assign o_snoozed     = r_snoozed;

    always_comb begin
        n_clock    = r_clock;
        n_tick     = r_tick;
        n_time_set = r_time_set;
        n_snz_pend = r_snz_pend;
        n_snz_time = r_snz_time;
        n_event    = EV_NONE;
        tick_inc   = r_tick + TPS_W'(1);
        unique case (r_req)
            REQ_TICK: begin
                n_tick = tick_inc;
                if (tick_inc >= r_tps) begin
                    n_tick  = '0;
                    n_clock = adv_time;
                    // compare against the snooze time while one is pending
                    if (!r_snz_pend) begin
                        if (r_alarm_en && (adv_time == r_alarm)) begin
                            n_event = EV_RING;
                        end
                    end else if (r_alarm_en && (adv_time == r_snz_time)) begin
                        n_event    = EV_RING;
                        n_snz_pend = 1'b0;
                    end
                end
            end
            REQ_SET: begin
                n_clock    = r_new_time;
                n_time_set = 1'b1;
            end
            REQ_SNOOZE: begin
                n_snz_pend = 1'b1;
                n_snz_time = snz_calc;
            end
            REQ_CANCEL: begin
                n_event = EV_STOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req      <= t_req'(i_req_type);
            r_new_time <= i_new_time;
            r_snz_min  <= i_snooze_minutes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_tick     <= '0;
            r_time_set <= 1'b0;
            r_snz_pend <= 1'b0;
            r_snz_time <= '0;
        end else if (adv) begin
            r_clock    <= n_clock;
            r_tick     <= n_tick;
            r_time_set <= n_time_set;
            r_snz_pend <= n_snz_pend;
            r_snz_time <= n_snz_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps      <= TPS_RESET;
            r_alarm    <= '0;
            r_alarm_en <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TPS:    r_tps      <= i_cfg_data[TPS_W-1:0];
                CFG_ALARM:  r_alarm    <= i_cfg_data;
                CFG_ENABLE: r_alarm_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_time_now   <= n_clock;
            r_time_valid <= n_time_set;
            r_event      <= n_event;
            r_snoozed    <= n_snz_pend;
        end
    end

endmodule
